// File: design/mbc_pkg.sv
// ----------------------------------------------------------------------------
// Correction mixer package
// Shared types and codes for the step/ramp correction mixer.
// ----------------------------------------------------------------------------
package mbc_pkg;

    // Operation codes carried by an input transfer.
    typedef enum logic [1:0] {
        OP_LOAD_STEP = 2'd0,
        OP_LOAD_RAMP = 2'd1,
        OP_ADD_BLEP  = 2'd2,
        OP_SAMPLE    = 2'd3
    } t_op;

    // Register indexes on the configuration port.
    localparam logic REG_KEY_SCALING = 1'b0;
    localparam logic REG_LIMIT_FREQ  = 1'b1;

    // Limiting frequency bounds and the default, Q1.16.
    localparam logic [16:0] FREQ_MIN  = 17'd8192;
    localparam logic [16:0] FREQ_MAX  = 17'd65536;
    localparam logic [16:0] FREQ_HALF = 17'd32768;

    localparam logic signed [23:0] Q420_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Q420_MIN = -24'sh800000;

    typedef struct packed {
        logic        key_scaling_on;
        logic [16:0] limiting_freq;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SMP,
        S_INIT,
        S_CHK,
        S_RD1,
        S_RD2,
        S_MUL1,
        S_MUL2,
        S_ACC
    } t_state;

endpackage

// File: design/minblep_correction_mixer_core.sv
// ----------------------------------------------------------------------------
// Step/ramp correction mixer for oscillators
// After reset the correction ring is cleared, one slot per cycle; no input
// transfer is taken then, but configuration writes are. Items are then
// handled one at a time. A table load is written as it is taken. A sample
// reads its ring slot, then, once the output register is free, sums,
// saturates, clears the slot and hands the result to the output register,
// which lets the next item in while the result waits. A blep walks the
// step and the ramp part with a positive magnitude, one after the other,
// each over L = TABLE_SIZE * 65536 / stride ring slots, at most 256 with
// the default sizes. Each slot passes through a check, two table reads
// (the single read port of each table memory reads the two interpolation
// taps one after the other), two multiply stages and the read-modify-write
// of the ring memory.
// ----------------------------------------------------------------------------
module minblep_correction_mixer_core #(
    parameter int TABLE_SIZE = 1024,
    parameter int RING_SIZE  = 512,
    parameter int OVERSAMPLE = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Item input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_operation,
    input  logic [9:0]         i_table_index,
    input  logic signed [17:0] i_table_value,
    input  logic [15:0]        i_blep_offset,
    input  logic signed [23:0] i_step_magnitude,
    input  logic signed [23:0] i_ramp_magnitude,
    input  logic signed [23:0] i_sample_in,
    // Result output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_sample_out,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Table address, index-with-overflow, position and accumulator widths.
    localparam int TAW  = $clog2(TABLE_SIZE);
    localparam int IW   = TAW + 2;
    localparam int PW   = TAW + 26;
    localparam int AW   = TAW + 18;
    localparam int RW   = $clog2(RING_SIZE);
    localparam int SBW  = RW + 9;
    localparam int SW   = $clog2(OVERSAMPLE) + 18;
    localparam logic [AW-1:0]  LIMIT     = AW'(TABLE_SIZE) << 16;
    localparam logic [IW-1:0]  TAB_END   = IW'(TABLE_SIZE);
    localparam logic [IW-1:0]  TAB_LAST  = IW'(TABLE_SIZE - 1);
    localparam logic [RW-1:0]  RING_LAST = RW'(RING_SIZE - 1);
    localparam logic [SBW-1:0] RING_SZ   = SBW'(RING_SIZE);

    // Saturation bounds widened once for the sum compares.
    localparam logic signed [29:0] Q420_MAX_EXT = 30'sd8388607;
    localparam logic signed [29:0] Q420_MIN_EXT = -30'sd8388608;

    mbc_pkg::t_cfg cfg;

    mbc_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Control state.
    mbc_pkg::t_state r_state, n_state;
    logic [RW-1:0]   r_clr_addr, n_clr_addr;
    logic [RW-1:0]   r_rp, n_rp;
    logic            r_out_valid, n_out_valid;
    logic            r_pass, n_pass;
    logic            r_run_ramp, n_run_ramp;

    // Payload and datapath registers.
    logic signed [23:0] r_out, n_out;
    logic signed [23:0] r_smp, n_smp;
    logic [SW-1:0]      r_stride, n_stride;
    logic [7:0]         r_fr, n_fr;
    logic [RW-1:0]      r_base, n_base;
    logic [RW-1:0]      r_slot, n_slot;
    logic signed [23:0] r_step_mag, n_step_mag;
    logic signed [23:0] r_ramp_mag, n_ramp_mag;
    logic [PW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_acc, n_acc;
    logic signed [17:0] r_v1, n_v1;
    logic signed [35:0] r_val, n_val;
    logic signed [48:0] r_pl, n_pl;
    logic signed [47:0] r_ph, n_ph;

    // Memory ports.
    logic              step_we, ramp_we, ring_we;
    logic [TAW-1:0]    tab_waddr, tab_raddr;
    logic [17:0]       step_rdata, ramp_rdata;
    logic [RW-1:0]     ring_waddr, ring_raddr;
    logic [23:0]       ring_wdata, ring_rdata;

    mbc_ram #(.WIDTH(18), .DEPTH(TABLE_SIZE)) u_step_tab (
        .i_clk   (i_clk),
        .i_we    (step_we),
        .i_waddr (tab_waddr),
        .i_wdata (i_table_value),
        .i_raddr (tab_raddr),
        .o_rdata (step_rdata)
    );

    mbc_ram #(.WIDTH(18), .DEPTH(TABLE_SIZE)) u_ramp_tab (
        .i_clk   (i_clk),
        .i_we    (ramp_we),
        .i_waddr (tab_waddr),
        .i_wdata (i_table_value),
        .i_raddr (tab_raddr),
        .o_rdata (ramp_rdata)
    );

    mbc_ram #(.WIDTH(24), .DEPTH(RING_SIZE)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    // Helper values for the combinational block.
    logic               accept;
    logic               load_ok;
    logic [16:0]        freq;
    logic [SBW-1:0]     base_sum;
    logic [IW-1:0]      i1, i1p, i2;
    logic signed [17:0] tab_rdata;
    logic signed [18:0] diff;
    logic signed [23:0] mag;
    logic signed [60:0] prod;
    logic signed [28:0] corr;
    logic signed [29:0] ring_sum;
    logic signed [24:0] smp_sum;

    assign o_in_ready   = (r_state == mbc_pkg::S_IDLE);
    assign accept       = i_in_valid & o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    assign load_ok   = (32'(i_table_index) < 32'(TABLE_SIZE));
    assign tab_waddr = TAW'(i_table_index);
    assign step_we   = accept && (i_operation == mbc_pkg::OP_LOAD_STEP) && load_ok;
    assign ramp_we   = accept && (i_operation == mbc_pkg::OP_LOAD_RAMP) && load_ok;

    // Interpolation taps: the upper one is clamped to the last entry, and a
    // lower tap past the table end reads as zero.
    assign i1        = r_pos[PW-1:24];
    assign i1p       = i1 + IW'(1);
    assign i2        = (i1p < TAB_END) ? i1p : TAB_LAST;
    assign tab_rdata = r_pass ? $signed(ramp_rdata) : $signed(step_rdata);
    assign diff      = 19'(tab_rdata) - 19'(r_v1);
    assign mag       = r_pass ? r_ramp_mag : r_step_mag;

    // Product assembled from the two magnitude halves, then rounded to
    // nearest with ties upward and dropped to Q4.20.
    assign prod     = (61'(r_ph) <<< 12) + 61'(r_pl);
    assign corr     = 29'((prod + 61'sd2147483648) >>> 32);
    assign ring_sum = 30'($signed(ring_rdata)) + 30'(corr);
    assign smp_sum  = 25'(r_smp) + 25'($signed(ring_rdata));

    always_comb begin
        // Limiting frequency, saturated, or one half without key scaling.
        if (cfg.key_scaling_on) begin
            if (cfg.limiting_freq < mbc_pkg::FREQ_MIN) begin
                freq = mbc_pkg::FREQ_MIN;
            end else if (cfg.limiting_freq > mbc_pkg::FREQ_MAX) begin
                freq = mbc_pkg::FREQ_MAX;
            end else begin
                freq = cfg.limiting_freq;
            end
        end else begin
            freq = mbc_pkg::FREQ_HALF;
        end

        // First ring slot of a blep, reduced into the ring.
        base_sum = SBW'(r_rp) + SBW'(i_blep_offset[15:8]);
        for (int s = 0; s < 4; s++) begin
            if (base_sum >= RING_SZ) begin
                base_sum = base_sum - RING_SZ;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_rp        = r_rp;
        n_out_valid = r_out_valid;
        n_pass      = r_pass;
        n_run_ramp  = r_run_ramp;
        n_out       = r_out;
        n_smp       = r_smp;
        n_stride    = r_stride;
        n_fr        = r_fr;
        n_base      = r_base;
        n_slot      = r_slot;
        n_step_mag  = r_step_mag;
        n_ramp_mag  = r_ramp_mag;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_v1        = r_v1;
        n_val       = r_val;
        n_pl        = r_pl;
        n_ph        = r_ph;

        tab_raddr  = TAW'(i1);
        ring_raddr = r_slot;
        ring_we    = 1'b0;
        ring_waddr = r_slot;
        ring_wdata = 24'd0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            mbc_pkg::S_CLR: begin
                ring_we    = 1'b1;
                ring_waddr = r_clr_addr;
                n_clr_addr = r_clr_addr + RW'(1);
                if (r_clr_addr == RING_LAST) begin
                    n_clr_addr = '0;
                    n_state    = mbc_pkg::S_IDLE;
                end
            end
            mbc_pkg::S_IDLE: begin
                ring_raddr = r_rp;
                if (accept) begin
                    if (i_operation == mbc_pkg::OP_SAMPLE) begin
                        n_smp   = i_sample_in;
                        n_state = mbc_pkg::S_SMP;
                    end else if (i_operation == mbc_pkg::OP_ADD_BLEP) begin
                        n_stride   = SW'(OVERSAMPLE * int'(freq));
                        n_fr       = i_blep_offset[7:0];
                        n_base     = RW'(base_sum);
                        n_step_mag = i_step_magnitude;
                        n_ramp_mag = i_ramp_magnitude;
                        n_run_ramp = (i_ramp_magnitude > 24'sd0);
                        n_pass     = (i_step_magnitude > 24'sd0) ? 1'b0 : 1'b1;
                        if ((i_step_magnitude > 24'sd0) || (i_ramp_magnitude > 24'sd0)) begin
                            n_state = mbc_pkg::S_INIT;
                        end
                    end
                end
            end
            mbc_pkg::S_SMP: begin
                // Slot data arrived; wait only while the output register is full and not being taken.
                ring_raddr = r_rp;
                if (!r_out_valid || i_out_ready) begin
                    if (smp_sum > 25'(Q420_MAX_EXT)) begin
                        n_out = mbc_pkg::Q420_MAX;
                    end else if (smp_sum < 25'(Q420_MIN_EXT)) begin
                        n_out = mbc_pkg::Q420_MIN;
                    end else begin
                        n_out = 24'(smp_sum);
                    end
                    n_out_valid = 1'b1;
                    ring_we     = 1'b1;
                    ring_waddr  = r_rp;
                    n_rp        = (r_rp == RING_LAST) ? '0 : r_rp + RW'(1);
                    n_state     = mbc_pkg::S_IDLE;
                end
            end
            mbc_pkg::S_INIT: begin
                n_pos   = PW'({1'b0, 9'd256 - 9'(r_fr)} * r_stride);
                n_acc   = AW'(r_stride);
                n_slot  = r_base;
                n_state = mbc_pkg::S_CHK;
            end
            mbc_pkg::S_CHK: begin
                if (r_acc > LIMIT) begin
                    if (!r_pass && r_run_ramp) begin
                        n_pass  = 1'b1;
                        n_state = mbc_pkg::S_INIT;
                    end else begin
                        n_state = mbc_pkg::S_IDLE;
                    end
                end else begin
                    n_state = mbc_pkg::S_RD1;
                end
            end
            mbc_pkg::S_RD1: begin
                tab_raddr = TAW'(i1);
                n_state   = mbc_pkg::S_RD2;
            end
            mbc_pkg::S_RD2: begin
                tab_raddr = TAW'(i2);
                n_v1      = (i1 >= TAB_END) ? 18'sd0 : tab_rdata;
                n_state   = mbc_pkg::S_MUL1;
            end
            mbc_pkg::S_MUL1: begin
                tab_raddr = TAW'(i2);
                n_v1      = r_v1;
                n_val     = (36'(r_v1) <<< 16)
                          + 36'(diff * $signed({1'b0, r_pos[23:8]}));
                n_state   = mbc_pkg::S_MUL2;
            end
            mbc_pkg::S_MUL2: begin
                n_pl    = 49'(r_val * $signed({1'b0, mag[11:0]}));
                n_ph    = 48'(r_val * $signed(mag[23:12]));
                n_state = mbc_pkg::S_ACC;
            end
            mbc_pkg::S_ACC: begin
                ring_we = 1'b1;
                if (ring_sum > 30'(Q420_MAX_EXT)) begin
                    ring_wdata = mbc_pkg::Q420_MAX;
                end else if (ring_sum < 30'(Q420_MIN_EXT)) begin
                    ring_wdata = mbc_pkg::Q420_MIN;
                end else begin
                    ring_wdata = 24'(ring_sum);
                end
                n_pos   = r_pos + PW'({r_stride, 8'd0});
                n_acc   = r_acc + AW'(r_stride);
                n_slot  = (r_slot == RING_LAST) ? '0 : r_slot + RW'(1);
                n_state = mbc_pkg::S_CHK;
            end
            default: begin
                n_state = mbc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbc_pkg::S_CLR;
            r_clr_addr  <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
            r_pass      <= 1'b0;
            r_run_ramp  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_rp        <= n_rp;
            r_out_valid <= n_out_valid;
            r_pass      <= n_pass;
            r_run_ramp  <= n_run_ramp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_smp      <= n_smp;
        r_stride   <= n_stride;
        r_fr       <= n_fr;
        r_base     <= n_base;
        r_slot     <= n_slot;
        r_step_mag <= n_step_mag;
        r_ramp_mag <= n_ramp_mag;
        r_pos      <= n_pos;
        r_acc      <= n_acc;
        r_v1       <= n_v1;
        r_val      <= n_val;
        r_pl       <= n_pl;
        r_ph       <= n_ph;
    end

    // No item may enter while the ring is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbc_pkg::S_CLR) |-> !o_in_ready)
        else $error("input taken during ring clear");

    // A sample that leaves its state must have loaded the output register.
    a_sample_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbc_pkg::S_SMP) && (n_state == mbc_pkg::S_IDLE) |=> o_out_valid)
        else $error("sample finished without a result");

    // The read position moves only when a sample completes.
    a_rp_moves_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mbc_pkg::S_SMP) |=> $stable(r_rp))
        else $error("read position moved outside a sample");

    // A blep with a positive step part starts its walk.
    a_blep_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_operation == mbc_pkg::OP_ADD_BLEP) && (i_step_magnitude > 24'sd0)
        |=> (r_state == mbc_pkg::S_INIT) && !r_pass)
        else $error("blep did not start its walk");

endmodule

// File: design/mbc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mbc_ram #(
    parameter int WIDTH  = 18,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/mbc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding key scaling and the limiting frequency.
// ----------------------------------------------------------------------------
module mbc_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mbc_pkg::t_cfg     o_cfg
);

    mbc_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_scaling_on <= 1'b0;
            r_cfg.limiting_freq  <= mbc_pkg::FREQ_HALF;
        end else if (wr_en) begin
            if (paddr[2] == mbc_pkg::REG_KEY_SCALING) begin
                r_cfg.key_scaling_on <= pwdata[0];
            end else begin
                r_cfg.limiting_freq <= pwdata[16:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == mbc_pkg::REG_LIMIT_FREQ) begin
            prdata = {15'd0, r_cfg.limiting_freq};
        end else begin
            prdata = {31'd0, r_cfg.key_scaling_on};
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: bench/minblep_correction_mixer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Correction mixer checker
// Watches the item and result channels, keeps a bit-exact model of the
// correction tables and ring, and compares every corrected sample it sees.
// ----------------------------------------------------------------------------
module minblep_correction_mixer_checker #(
    parameter int TABLE_SIZE = 1024,
    parameter int RING_SIZE  = 512,
    parameter int OVERSAMPLE = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_operation,
    input  logic [9:0]         i_table_index,
    input  logic signed [17:0] i_table_value,
    input  logic [15:0]        i_blep_offset,
    input  logic signed [23:0] i_step_magnitude,
    input  logic signed [23:0] i_ramp_magnitude,
    input  logic signed [23:0] i_sample_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [23:0] i_sample_out,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_errors,
    output int                 o_pending
);

    logic signed [17:0] step_tab [TABLE_SIZE];
    logic signed [17:0] ramp_tab [TABLE_SIZE];
    logic signed [23:0] ring [RING_SIZE];
    int unsigned        rd_pos;
    logic               scale_on;
    logic [16:0]        limit_freq;
    logic signed [23:0] expected_samples [$];

    function automatic logic signed [23:0] clamp24(input longint x);
        if (x > longint'(mbc_pkg::Q420_MAX)) return mbc_pkg::Q420_MAX;
        if (x < longint'(mbc_pkg::Q420_MIN)) return mbc_pkg::Q420_MIN;
        return x[23:0];
    endfunction

    // Adds one magnitude-scaled, interpolated table sweep into the ring.
    task automatic add_sweep(input bit use_ramp, input longint mag, input longint len,
                             input longint first, input longint frac, input longint stride);
        longint pos, i1, i2, t, v1, v2, val, corr;
        int unsigned slot;
        for (longint k = 0; k < len; k++) begin
            pos = (256 - frac + 256 * k) * stride;
            i1  = pos >>> 24;
            i2  = (i1 + 1 < TABLE_SIZE) ? i1 + 1 : TABLE_SIZE - 1;
            t   = (pos >>> 8) & 64'hFFFF;
            v1  = (i1 < TABLE_SIZE) ? (use_ramp ? ramp_tab[i1] : step_tab[i1]) : 0;
            v2  = use_ramp ? ramp_tab[i2] : step_tab[i2];
            val = v1 * 65536 + (v2 - v1) * t;
            // Arithmetic shift floors, giving round-half-up.
            corr = (val * mag + (64'sd1 <<< 31)) >>> 32;
            slot = (rd_pos + first + k) % RING_SIZE;
            ring[slot] = clamp24(longint'(ring[slot]) + corr);
        end
    endtask

    task automatic absorb_item();
        longint f, stride, len;
        mbc_pkg::t_op op;
        op = mbc_pkg::t_op'(i_operation);
        case (op)
            mbc_pkg::OP_LOAD_STEP: begin
                if (i_table_index < TABLE_SIZE) step_tab[i_table_index] = i_table_value;
            end
            mbc_pkg::OP_LOAD_RAMP: begin
                if (i_table_index < TABLE_SIZE) ramp_tab[i_table_index] = i_table_value;
            end
            mbc_pkg::OP_ADD_BLEP: begin
                f = mbc_pkg::FREQ_HALF;
                if (scale_on) begin
                    f = limit_freq;
                    if (f < mbc_pkg::FREQ_MIN) f = mbc_pkg::FREQ_MIN;
                    if (f > mbc_pkg::FREQ_MAX) f = mbc_pkg::FREQ_MAX;
                end
                stride = OVERSAMPLE * f;
                len    = (longint'(TABLE_SIZE) * 65536) / stride;
                if (i_step_magnitude > 0)
                    add_sweep(1'b0, i_step_magnitude, len, i_blep_offset >> 8,
                              i_blep_offset & 16'hFF, stride);
                if (i_ramp_magnitude > 0)
                    add_sweep(1'b1, i_ramp_magnitude, len, i_blep_offset >> 8,
                              i_blep_offset & 16'hFF, stride);
            end
            default: begin
                expected_samples.push_back(
                    clamp24(longint'(i_sample_in) + longint'(ring[rd_pos])));
                ring[rd_pos] = '0;
                rd_pos = (rd_pos + 1) % RING_SIZE;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (ring[j]) ring[j] = '0;
            foreach (step_tab[j]) begin
                step_tab[j] = '0;
                ramp_tab[j] = '0;
            end
            rd_pos     = 0;
            scale_on   = 1'b0;
            limit_freq = mbc_pkg::FREQ_HALF;
            expected_samples.delete();
            o_errors   = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample_out: none expected, actual %0d", i_sample_out);
                    o_errors++;
                end else begin
                    if (i_sample_out !== expected_samples[0]) begin
                        $error("sample_out: expected %0d, actual %0d",
                               expected_samples[0], i_sample_out);
                        o_errors++;
                    end
                    void'(expected_samples.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) absorb_item();
            if (i_psel && i_penable && i_pwrite) begin
                if (i_paddr[2] == mbc_pkg::REG_KEY_SCALING) scale_on = i_pwdata[0];
                else limit_freq = i_pwdata[16:0];
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

// File: bench/minblep_correction_mixer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Correction mixer testbench
// Loads both correction tables, then drives directed and random blep and
// sample transfers and random table loads under varying stall patterns
// across several register settings. A checker beside the block predicts every corrected sample.
// ----------------------------------------------------------------------------
module minblep_correction_mixer_core_tb;

    localparam int TABLE_SIZE = 1024;
    localparam int CYCLE_LIMIT = 20000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         operation = '0;
    logic [9:0]         table_index = '0;
    logic signed [17:0] table_value = '0;
    logic [15:0]        blep_offset = '0;
    logic signed [23:0] step_mag = '0;
    logic signed [23:0] ramp_mag = '0;
    logic signed [23:0] sample_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [23:0] sample_out;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int errors;
    int pending;
    int cycles = 0;
    // Percent of cycles in which the sender and the receiver hold back.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    always #1 i_clk = ~i_clk;

    minblep_correction_mixer_core uut (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_operation(operation), .i_table_index(table_index),
        .i_table_value(table_value), .i_blep_offset(blep_offset),
        .i_step_magnitude(step_mag), .i_ramp_magnitude(ramp_mag),
        .i_sample_in(sample_in),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_sample_out(sample_out),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    minblep_correction_mixer_checker chk (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_operation(operation), .i_table_index(table_index),
        .i_table_value(table_value), .i_blep_offset(blep_offset),
        .i_step_magnitude(step_mag), .i_ramp_magnitude(ramp_mag),
        .i_sample_in(sample_in),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_sample_out(sample_out),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending)
    );

    // The receiver stalls at random, at the current idle rate.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // A hard ceiling on the run length, in case the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Setup cycle, then access cycle; pready is always high.
    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one transfer, keeping the payload stable until it is taken.
    // A random gap may precede it, as the sender's idle rate says.
    task automatic send_item(input mbc_pkg::t_op op, input logic [9:0] idx,
                             input logic signed [17:0] tval, input logic [15:0] off,
                             input logic signed [23:0] smag,
                             input logic signed [23:0] rmag,
                             input logic signed [23:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        table_index <= idx;
        table_value <= tval;
        blep_offset <= off;
        step_mag    <= smag;
        ramp_mag    <= rmag;
        sample_in   <= smp;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic idle_sender();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for every expected sample and then for the longest blep,
    // two full sweeps of 256 slots each, to finish.
    task automatic drain();
        idle_sender();
        while (pending != 0) @(posedge i_clk);
        repeat (3200) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic signed [23:0] smp);
        send_item(mbc_pkg::OP_SAMPLE, 10'($urandom), 18'($urandom), 16'($urandom),
                  24'($urandom), 24'($urandom), smp);
    endtask

    task automatic send_blep(input logic [15:0] off, input logic signed [23:0] smag,
                             input logic signed [23:0] rmag);
        send_item(mbc_pkg::OP_ADD_BLEP, 10'($urandom), 18'($urandom), off, smag, rmag,
                  24'($urandom));
    endtask

    // Random magnitude: mostly positive, sometimes zero or negative (skipped).
    function automatic logic signed [23:0] rand_mag();
        case ($urandom_range(9))
            0:       return '0;
            1:       return -$signed({1'b0, 23'($urandom)}) - 24'sd1;
            2:       return mbc_pkg::Q420_MAX;
            default: return {1'b0, 23'($urandom)};
        endcase
    endfunction

    task automatic random_phase(input int count);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 12)
                // Mostly nearby offsets so that corrections land on soon-read slots.
                send_blep(($urandom_range(3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(2047)),
                          rand_mag(), rand_mag());
            else if (pick < 15)
                send_item(mbc_pkg::t_op'($urandom_range(1)), 10'($urandom),
                          18'($urandom), 16'($urandom), 24'($urandom),
                          24'($urandom), 24'($urandom));
            else
                send_sample(24'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill both tables completely, so no entry is read unwritten.
        for (int j = 0; j < TABLE_SIZE; j++) begin
            send_item(mbc_pkg::OP_LOAD_STEP, 10'(j), 18'($urandom), 16'($urandom),
                      24'($urandom), 24'($urandom), 24'($urandom));
            send_item(mbc_pkg::OP_LOAD_RAMP, 10'(j), 18'($urandom), 16'($urandom),
                      24'($urandom), 24'($urandom), 24'($urandom));
        end
        // Directed table extremes, at the edges of the index range.
        send_item(mbc_pkg::OP_LOAD_STEP, 10'd1023, 18'sh1FFFF, '0, '0, '0, '0);
        send_item(mbc_pkg::OP_LOAD_RAMP, 10'd1023, -18'sh20000, '0, '0, '0, '0);
        send_item(mbc_pkg::OP_LOAD_STEP, 10'd0, -18'sh20000, '0, '0, '0, '0);
        send_item(mbc_pkg::OP_LOAD_RAMP, 10'd0, 18'sh1FFFF, '0, '0, '0, '0);

        // Directed: extreme offsets, skipped magnitudes, saturation both ways.
        send_blep(16'h0000, mbc_pkg::Q420_MAX, mbc_pkg::Q420_MAX);
        send_blep(16'h0000, mbc_pkg::Q420_MAX, mbc_pkg::Q420_MAX);
        send_blep(16'h00FF, 24'sd1, 24'sd0);
        send_blep(16'hFFFF, -24'sd1, mbc_pkg::Q420_MIN);
        send_blep(16'h0180, mbc_pkg::Q420_MIN, 24'sd77);
        send_sample(mbc_pkg::Q420_MAX);
        send_sample(mbc_pkg::Q420_MIN);
        send_sample('0);
        send_sample(-24'sd1);
        send_sample(24'sd1);
        send_sample(mbc_pkg::Q420_MIN);
        drain();

        // Phase A: sender rarely idles, receiver mostly stalls; default settings.
        send_idle_pct = 18;
        recv_idle_pct = 88;
        random_phase(300);
        drain();

        // Scaling on at both extremes and beyond them (saturation).
        reg_write(mbc_pkg::REG_KEY_SCALING, 32'd1);
        reg_write(mbc_pkg::REG_LIMIT_FREQ, 32'd65536);
        random_phase(150);
        drain();
        reg_write(mbc_pkg::REG_LIMIT_FREQ, 32'h1FFFF);
        random_phase(100);
        drain();
        reg_write(mbc_pkg::REG_LIMIT_FREQ, 32'd8192);

        // Phase B: the other way round.
        send_idle_pct = 88;
        recv_idle_pct = 18;
        random_phase(150);
        drain();
        reg_write(mbc_pkg::REG_LIMIT_FREQ, 32'd0);
        random_phase(100);
        drain();

        // Phase C: no idling, a middle frequency, then scaling back off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        reg_write(mbc_pkg::REG_LIMIT_FREQ, 32'($urandom_range(8192, 65536)));
        random_phase(200);
        drain();
        reg_write(mbc_pkg::REG_KEY_SCALING, 32'd0);
        random_phase(200);
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
